// ----- src/mpic_pkg.sv -----
package mpic_pkg;

    // Channel map of the three pin ports
    localparam int CHANNELS    = 16;
    localparam int CH_BITS     = 4;
    localparam int PORT_A_BITS = 8;
    localparam int PORT_B_BITS = 2;
    localparam int PORT_C_BITS = 6;
    localparam int PORT_B_BASE = 8;
    localparam int PORT_C_BASE = 10;
    localparam int IVAL_BITS   = 32;

    // One result word as it travels down the chain
    typedef struct packed {
        logic [CH_BITS-1:0]   edge_channel;
        logic [IVAL_BITS-1:0] interval_ticks;
        logic                 last_of_tick;
    } result_t;

    // Per-cycle control shared by every cell
    typedef struct packed {
        logic load;   // capture a fresh tick into all cells
        logic shift;  // move every word one cell towards the output
    } cell_ctrl_t;

endpackage

// ----- src/mpic_if.sv -----
// Input channel: one timer tick with the sampled pins
interface mpic_sample_if;
    logic                               valid;
    logic                               ready;
    logic [mpic_pkg::PORT_A_BITS-1:0]   port_a_pins;
    logic [mpic_pkg::PORT_B_BITS-1:0]   port_b_pins;
    logic [mpic_pkg::PORT_C_BITS-1:0]   port_c_pins;

    modport source (output valid, port_a_pins, port_b_pins, port_c_pins, input ready);
    modport sink   (input valid, port_a_pins, port_b_pins, port_c_pins, output ready);
endinterface

// Output channel: one edge result
interface mpic_capture_if;
    logic                               valid;
    logic                               ready;
    logic [mpic_pkg::CH_BITS-1:0]       edge_channel;
    logic [mpic_pkg::IVAL_BITS-1:0]     interval_ticks;
    logic                               last_of_tick;

    modport source (output valid, edge_channel, interval_ticks, last_of_tick, input ready);
    modport sink   (input valid, edge_channel, interval_ticks, last_of_tick, output ready);
endinterface

// ----- src/mpic_cell.sv -----
// One channel: keeps its last edge time and one slot of the result chain
module mpic_cell #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mpic_pkg::cell_ctrl_t         ctrl,
    input  logic [mpic_pkg::CH_BITS-1:0] channel_id,
    input  logic [TIME_WIDTH-1:0]        tick_next,
    input  logic                         rise,
    input  logic                         last_rise,
    input  logic                         up_valid,
    input  mpic_pkg::result_t            up_data,
    output logic                         valid,
    output mpic_pkg::result_t            data
);

    logic [TIME_WIDTH-1:0] time_reg;
    logic [TIME_WIDTH-1:0] time_next;
    logic [TIME_WIDTH-1:0] diff;
    logic                  valid_reg;
    logic                  valid_next;
    mpic_pkg::result_t     data_reg;
    mpic_pkg::result_t     data_next;

    // Modular interval against the stored edge time
    assign diff = tick_next - time_reg;

    // Load on a tick, otherwise take the neighbour's word on a shift
    always_comb
    begin
        time_next  = time_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.load)
        begin
            valid_next                = rise;
            data_next.edge_channel    = channel_id;
            data_next.interval_ticks  = mpic_pkg::IVAL_BITS'(diff);
            data_next.last_of_tick    = last_rise;
            if (rise)
            begin
                time_next = tick_next;
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = up_valid;
            data_next  = up_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            time_reg  <= time_next;
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- src/multichannel_pulse_interval_capture_core.sv -----
// Channel   Dir   Handshake      Word
// sample    in    valid/ready    port_a_pins[8], port_b_pins[2], port_c_pins[6]
// capture   out   valid/ready    edge_channel[4], interval_ticks[32], last_of_tick
//
// A tick is taken only when the cell chain is empty; it loads all 16 cells at
// once and the words shift one cell a cycle towards the output register while
// it is free or cell 0 is empty. A tick holds the input off until the word of
// its highest rising channel has left the chain; one with no edge does not.
// The output register lets the next tick enter while a result waits.
// Reset clears the timestamp, the pin history and every stored edge time.
// A stalled capture channel holds the chain; no word is lost.
module multichannel_pulse_interval_capture_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mpic_sample_if.sink           sample,
    mpic_capture_if.source        capture
);

    localparam int CH = mpic_pkg::CHANNELS;

    logic [TIME_WIDTH-1:0]   tick_reg;
    logic [TIME_WIDTH-1:0]   tick_next;
    logic [CH-1:0]           prev_reg;
    logic [CH-1:0]           prev_next;
    logic [CH-1:0]           pins;
    logic [CH-1:0]           rise;
    logic [CH-1:0]           last_rise;
    logic [CH-1:0]           cell_valid;
    mpic_pkg::result_t       cell_data [CH];
    logic [CH-1:0]           up_valid;
    mpic_pkg::result_t       up_data [CH];
    mpic_pkg::cell_ctrl_t    ctrl;
    logic                    chain_busy;
    logic                    accept;
    logic                    out_free;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    mpic_pkg::result_t       out_data_reg;
    mpic_pkg::result_t       out_data_next;

    // Pin sample and edge detection
    assign pins = {sample.port_c_pins, sample.port_b_pins, sample.port_a_pins};
    assign rise = pins & ~prev_reg;

    // Handshake and chain control
    assign chain_busy   = |cell_valid;
    assign sample.ready = !chain_busy;
    assign accept       = sample.valid && !chain_busy;
    assign out_free     = !out_valid_reg || capture.ready;
    assign ctrl.load    = accept;
    assign ctrl.shift   = chain_busy && (out_free || !cell_valid[0]);

    // Timestamp and pin history
    always_comb
    begin
        tick_next = tick_reg;
        prev_next = prev_reg;
        if (accept)
        begin
            tick_next = tick_reg + TIME_WIDTH'(1);
            prev_next = pins;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            prev_reg <= '0;
        end
        else
        begin
            tick_reg <= tick_next;
            prev_reg <= prev_next;
        end
    end

    // Cell row; cell i hands its word to cell i-1, cell 0 feeds the output
    genvar gi;
    generate
        for (gi = 0; gi < CH; gi++)
        begin : g_cell
            if (gi == CH - 1)
            begin : g_end
                assign last_rise[gi] = rise[gi];
                assign up_valid[gi]  = 1'b0;
                assign up_data[gi]   = '0;
            end
            else
            begin : g_mid
                // last edge of the tick when no higher channel rises
                assign last_rise[gi] = rise[gi] && !(|rise[CH-1:gi+1]);
                assign up_valid[gi]  = cell_valid[gi+1];
                assign up_data[gi]   = cell_data[gi+1];
            end

            mpic_cell #(
                .TIME_WIDTH (TIME_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .channel_id (mpic_pkg::CH_BITS'(gi)),
                .tick_next  (tick_next),
                .rise       (rise[gi]),
                .last_rise  (last_rise[gi]),
                .up_valid   (up_valid[gi]),
                .up_data    (up_data[gi]),
                .valid      (cell_valid[gi]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (ctrl.shift && cell_valid[0])
        begin
            out_valid_next = 1'b1;
            out_data_next  = cell_data[0];
        end
        else if (capture.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign capture.valid          = out_valid_reg;
    assign capture.edge_channel   = out_data_reg.edge_channel;
    assign capture.interval_ticks = out_data_reg.interval_ticks;
    assign capture.last_of_tick   = out_data_reg.last_of_tick;

`ifndef SYNTHESIS
    // a loaded tick fills exactly the cells of the rising channels
    a_load_map: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cell_valid == $past(rise))
        else $error("chain load does not match rising edges");

    // timestamp only moves on an accepted tick
    a_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> tick_reg == $past(tick_reg))
        else $error("timestamp moved without a tick");

    // a result that is not the last of its tick has successors in the chain
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.last_of_tick) |-> chain_busy)
        else $error("non-final result with empty chain");

    // the output register is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !capture.ready) |-> !(ctrl.shift && cell_valid[0]))
        else $error("stalled result overwritten");
`endif

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 4;
    localparam int N_ROWS       = 20;
    localparam int N_PHASES     = 4;
    localparam int PHASE_TICKS  = 22;
    localparam int TAIL_CYCLES  = 40;
    localparam int STALL_LIMIT  = 2000;

    // Directed row: pin sample, plus a hand-written word where it is obvious
    typedef struct packed {
        logic [mpic_pkg::PORT_A_BITS-1:0] a;
        logic [mpic_pkg::PORT_B_BITS-1:0] b;
        logic [mpic_pkg::PORT_C_BITS-1:0] c;
        logic                             typed;
        logic                             has_word;
        logic [mpic_pkg::CH_BITS-1:0]     ch;
        logic [mpic_pkg::IVAL_BITS-1:0]   ival;
    } tick_row_t;

    logic clk;
    logic rst_n;

    mpic_sample_if  sample ();
    mpic_capture_if capture ();

    multichannel_pulse_interval_capture_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample),
        .capture (capture)
    );

    // Shadow state of the capture logic
    logic [31:0]                   model_ticks;
    logic [mpic_pkg::CHANNELS-1:0] model_pins;
    logic [31:0]                   model_edge_time [mpic_pkg::CHANNELS];

    mpic_pkg::result_t tick_words [$];
    mpic_pkg::result_t pending_captures [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int ticks_sent;
    int words_checked;
    int idle_cycles;

    tick_row_t tick_rows [N_ROWS] = '{
        '{8'h00, 2'b00, 6'h00, 1'b1, 1'b0, 4'd0,  32'd0},  // nothing after reset
        '{8'h01, 2'b00, 6'h00, 1'b1, 1'b1, 4'd0,  32'd2},  // first edge, ch0
        '{8'h01, 2'b00, 6'h00, 1'b1, 1'b0, 4'd0,  32'd0},  // level held high
        '{8'h00, 2'b00, 6'h00, 1'b1, 1'b0, 4'd0,  32'd0},  // falling edge only
        '{8'h01, 2'b00, 6'h00, 1'b1, 1'b1, 4'd0,  32'd3},  // ch0 rises again
        '{8'h00, 2'b00, 6'h20, 1'b1, 1'b1, 4'd15, 32'd6},  // top channel
        '{8'h00, 2'b00, 6'h00, 1'b1, 1'b0, 4'd0,  32'd0},
        '{8'hFF, 2'b11, 6'h3F, 1'b0, 1'b0, 4'd0,  32'd0},  // all sixteen rise
        '{8'h00, 2'b00, 6'h00, 1'b1, 1'b0, 4'd0,  32'd0},
        '{8'hFF, 2'b11, 6'h3F, 1'b0, 1'b0, 4'd0,  32'd0},  // all rise again
        '{8'h00, 2'b00, 6'h00, 1'b1, 1'b0, 4'd0,  32'd0},
        '{8'h00, 2'b01, 6'h00, 1'b1, 1'b1, 4'd8,  32'd2},  // port B low bit
        '{8'h00, 2'b00, 6'h00, 1'b1, 1'b0, 4'd0,  32'd0},
        '{8'h00, 2'b10, 6'h00, 1'b1, 1'b1, 4'd9,  32'd4},  // port B high bit
        '{8'h00, 2'b00, 6'h00, 1'b1, 1'b0, 4'd0,  32'd0},
        '{8'h00, 2'b00, 6'h01, 1'b1, 1'b1, 4'd10, 32'd6},  // port C low bit
        '{8'h80, 2'b00, 6'h00, 1'b1, 1'b1, 4'd7,  32'd7},  // port A top bit
        '{8'hAA, 2'b10, 6'h15, 1'b0, 1'b0, 4'd0,  32'd0},  // odd/even patterns
        '{8'h55, 2'b01, 6'h2A, 1'b0, 1'b0, 4'd0,  32'd0},
        '{8'h00, 2'b00, 6'h00, 1'b1, 1'b0, 4'd0,  32'd0}
    };

    // Advance the shadow state by one tick and list the edge words it gives
    function automatic void compute_intervals(input logic [mpic_pkg::CHANNELS-1:0] pins);
        logic [mpic_pkg::CHANNELS-1:0] rising;
        mpic_pkg::result_t             w;
        begin
            tick_words.delete();
            model_ticks = model_ticks + 32'd1;
            rising      = pins & ~model_pins;
            model_pins  = pins;
            for (int ch = 0; ch < mpic_pkg::CHANNELS; ch++)
            begin
                if (rising[ch])
                begin
                    w.edge_channel   = mpic_pkg::CH_BITS'(ch);
                    w.interval_ticks = model_ticks - model_edge_time[ch];
                    w.last_of_tick   = 1'b0;
                    model_edge_time[ch] = model_ticks;
                    tick_words.push_back(w);
                end
            end
            if (tick_words.size() != 0)
                tick_words[tick_words.size()-1].last_of_tick = 1'b1;
        end
    endfunction

    // Offer one tick, with random idle cycles in front, and log what it should give
    task automatic send_tick(input tick_row_t row);
        mpic_pkg::result_t w;
        begin
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                sample.valid <= 1'b0;
                @(negedge clk);
            end
            sample.valid       <= 1'b1;
            sample.port_a_pins <= row.a;
            sample.port_b_pins <= row.b;
            sample.port_c_pins <= row.c;
            do
                @(posedge clk);
            while (!sample.ready);
            compute_intervals({row.c, row.b, row.a});
            if (row.typed)
            begin
                if (row.has_word)
                begin
                    w.edge_channel   = row.ch;
                    w.interval_ticks = row.ival;
                    w.last_of_tick   = 1'b1;
                    pending_captures.push_back(w);
                end
            end
            else
            begin
                foreach (tick_words[i])
                    pending_captures.push_back(tick_words[i]);
            end
            ticks_sent++;
        end
    endtask

    // Hold the sample channel quiet until every word has drained
    task automatic drain_captures;
        begin
            @(negedge clk);
            sample.valid <= 1'b0;
            while (pending_captures.size() != 0)
                @(posedge clk);
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // Receiver back-pressure
    always @(negedge clk)
    begin
        capture.ready <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
    end

    // Word checker and stall watchdog
    always @(posedge clk)
    begin
        mpic_pkg::result_t exp_w;
        if (rst_n && capture.valid && capture.ready)
        begin
            if (pending_captures.size() == 0)
            begin
                $error("capture word with nothing pending: ch %0d ival %0d last %0b",
                       capture.edge_channel, capture.interval_ticks, capture.last_of_tick);
                mismatch_count++;
            end
            else
            begin
                exp_w = pending_captures.pop_front();
                words_checked++;
                if (capture.edge_channel !== exp_w.edge_channel)
                begin
                    $error("edge_channel: expected %0d, got %0d",
                           exp_w.edge_channel, capture.edge_channel);
                    mismatch_count++;
                end
                if (capture.interval_ticks !== exp_w.interval_ticks)
                begin
                    $error("interval_ticks: expected %0d, got %0d",
                           exp_w.interval_ticks, capture.interval_ticks);
                    mismatch_count++;
                end
                if (capture.last_of_tick !== exp_w.last_of_tick)
                begin
                    $error("last_of_tick: expected %0b, got %0b",
                           exp_w.last_of_tick, capture.last_of_tick);
                    mismatch_count++;
                end
            end
        end

        if ((sample.valid && sample.ready) || (capture.valid && capture.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        tick_row_t                     r;
        int                            mode;
        logic [mpic_pkg::CHANNELS-1:0] pins;
        logic [mpic_pkg::CHANNELS-1:0] last_pins;

        rst_n              = 1'b0;
        sample.valid       = 1'b0;
        sample.port_a_pins = '0;
        sample.port_b_pins = '0;
        sample.port_c_pins = '0;
        capture.ready      = 1'b0;
        send_idle_pct      = 11;
        recv_stall_pct     = 11;
        mismatch_count     = 0;
        ticks_sent         = 0;
        words_checked      = 0;
        idle_cycles        = 0;
        last_pins          = '0;

        // Shadow state matches the cleared block
        model_ticks = '0;
        model_pins  = '0;
        foreach (model_edge_time[i])
            model_edge_time[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed ticks
        for (int i = 0; i < N_ROWS; i++)
        begin
            send_tick(tick_rows[i]);
        end
        last_pins = {tick_rows[N_ROWS-1].c, tick_rows[N_ROWS-1].b, tick_rows[N_ROWS-1].a};

        // Random ticks: free flow, sender gaps, receiver stalls, both
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain_captures();
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                mode = $urandom_range(9);
                case (mode)
                    5, 6: pins = '0;
                    7:    pins = '1;
                    8:    pins = mpic_pkg::CHANNELS'(1) << $urandom_range(mpic_pkg::CHANNELS-1);
                    9:    pins = ~last_pins;
                    default: pins = mpic_pkg::CHANNELS'($urandom);
                endcase
                last_pins  = pins;
                r          = '0;
                r.a        = pins[mpic_pkg::PORT_A_BITS-1:0];
                r.b        = pins[mpic_pkg::PORT_B_BASE +: mpic_pkg::PORT_B_BITS];
                r.c        = pins[mpic_pkg::PORT_C_BASE +: mpic_pkg::PORT_C_BITS];
                r.typed    = 1'b0;
                send_tick(r);
            end
        end

        // Let everything drain, then watch for strays
        drain_captures();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d ticks over four flow-control phases; checked %0d edge words.",
                 ticks_sent, words_checked);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
